>>> rtl/json_key_value_extractor_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key/value extractor
// Shared shorthand for clocked properties with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef JSON_KEY_VALUE_EXTRACTOR_DEFINES_SVH
`define JSON_KEY_VALUE_EXTRACTOR_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define KVE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define KVE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/kve_pkg.sv
// ----------------------------------------------------------------------------
// Key/value extractor package
// Shared types and character constants of the extractor.
// ----------------------------------------------------------------------------
package kve_pkg;

	localparam int unsigned KEY_BYTES = 16;
	localparam int unsigned CNT_W     = 14;

	localparam logic [CNT_W-1:0] COUNT_TOP = 14'd16383;

	localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_BLANKS = 2'd1,
		PH_VALUE  = 2'd2,
		PH_IDLE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [4:0]  key_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       final_byte;
	} msg_item_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       value_byte;
		logic [CNT_W-1:0] value_length;
		logic             run_last;
	} res_item_t;

endpackage

>>> rtl/kve_msg_if.sv
// ----------------------------------------------------------------------------
// Message byte channel
// Valid/ready channel that carries one message byte and its boundary marks.
// ----------------------------------------------------------------------------
interface kve_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output first_byte,
		output final_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte,
		input final_byte, output ready);
endinterface

>>> rtl/kve_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one extraction result.
// ----------------------------------------------------------------------------
interface kve_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  value_byte;
	logic [13:0] value_length;
	logic        run_last;

	modport source (output valid, output kind, output value_byte,
		output value_length, output run_last, input ready);
	modport sink (input valid, input kind, input value_byte,
		input value_length, input run_last, output ready);
endinterface

>>> rtl/kve_step.sv
// ----------------------------------------------------------------------------
// Extractor step
// Holds the per-message parse state and the key window, and works out the
// results that one registered byte causes.
// ----------------------------------------------------------------------------
module kve_step import kve_pkg::*; #(
	parameter int unsigned KEY_MAX = 16,
	parameter int unsigned MSG_MAX = 16384
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  msg_item_t item,
	input  logic      take,
	output logic      r0_vld,
	output res_item_t r0,
	output logic      r1_vld,
	output res_item_t r1
);

	localparam int unsigned FW = $clog2(KEY_MAX + 1);
	localparam int unsigned PW = $clog2(MSG_MAX);
	localparam logic [PW-1:0] POS_LIM = PW'(MSG_MAX - 1);
	localparam logic [FW-1:0] FILL_TOP = FW'(KEY_MAX);

	phase_t           phase_q;
	logic [FW-1:0]    fill_q;
	logic             inq_q;
	logic             esc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    pos_q;
	logic [7:0]       win_q [KEY_MAX];

	phase_t           e_phase, ph_proc, np;
	logic [FW-1:0]    e_fill, fill_n, nfill;
	logic             e_inq, e_esc, nq, ne;
	logic [CNT_W-1:0] e_cnt, cnt_bump, nc;
	logic [PW-1:0]    e_pos, npos;
	logic             in_range, shift, match;
	logic [4:0]       len;
	logic [7:0]       key_b [KEY_BYTES];
	logic [7:0]       win_n [KEY_MAX];
	logic [7:0]       b;
	logic             is_blank, is_delim, closed;

	assign b        = item.data_byte;
	assign is_blank = (b == CH_SPACE) || (b == CH_TAB);
	assign is_delim = (b == CH_COMMA) || (b == CH_RBRACK) || (b == CH_RBRACE);

	// A first mark restarts the message before the byte itself is looked at.
	assign e_phase = item.first_byte ? PH_SEARCH : phase_q;
	assign e_fill  = item.first_byte ? '0 : fill_q;
	assign e_inq   = item.first_byte ? 1'b0 : inq_q;
	assign e_esc   = item.first_byte ? 1'b0 : esc_q;
	assign e_cnt   = item.first_byte ? '0 : cnt_q;
	assign e_pos   = item.first_byte ? '0 : pos_q;

	assign in_range = e_pos < POS_LIM;
	assign fill_n   = (e_fill < FILL_TOP) ? e_fill + FW'(1) : e_fill;
	assign cnt_bump = (e_cnt < COUNT_TOP) ? e_cnt + CNT_W'(1) : e_cnt;

	always_comb begin
		if (cfg.key_len == 5'd0)
			len = 5'd1;
		else if (cfg.key_len > 5'(KEY_MAX))
			len = 5'(KEY_MAX);
		else
			len = cfg.key_len;
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			key_b[i]     = cfg.key_low[8*i +: 8];
			key_b[i + 8] = cfg.key_high[8*i +: 8];
		end
	end

	always_comb begin
		win_n[0] = b;
		for (int j = 1; j < KEY_MAX; j++)
			win_n[j] = win_q[j-1];
	end

	// The newest byte sits at window entry 0 and lines up with the last key byte.
	always_comb begin
		logic [4:0] kidx;
		kidx  = '0;
		match = (5'(fill_n) >= len);
		for (int j = 0; j < KEY_MAX; j++) begin
			kidx = len - 5'd1 - 5'(j);
			if ((5'(j) < len) && (win_n[j] != key_b[kidx[3:0]]))
				match = 1'b0;
		end
	end

	// Next state.
	always_comb begin
		ph_proc = e_phase;
		nq      = e_inq;
		ne      = e_esc;
		nc      = e_cnt;
		npos    = e_pos;
		nfill   = e_fill;
		shift   = 1'b0;
		if (in_range) begin
			npos = e_pos + PW'(1);
			unique case (e_phase)
				PH_SEARCH: begin
					shift = 1'b1;
					nfill = fill_n;
					if (match)
						ph_proc = PH_BLANKS;
				end
				PH_BLANKS: begin
					priority if (is_blank) begin
						ph_proc = PH_BLANKS;
					end else if (b == CH_QUOTE) begin
						nq      = 1'b1;
						ne      = 1'b0;
						ph_proc = PH_VALUE;
					end else if (is_delim) begin
						ph_proc = PH_IDLE;
					end else begin
						nq      = 1'b0;
						ph_proc = PH_VALUE;
						nc      = cnt_bump;
					end
				end
				PH_VALUE: begin
					if (e_inq) begin
						priority if (e_esc) begin
							ne = 1'b0;
							nc = cnt_bump;
						end else if (b == CH_QUOTE) begin
							ph_proc = PH_IDLE;
						end else begin
							ne = (b == CH_BSLASH);
							nc = cnt_bump;
						end
					end else if (is_delim) begin
						ph_proc = PH_IDLE;
					end else begin
						nc = cnt_bump;
					end
				end
				PH_IDLE: begin
					ph_proc = PH_IDLE;
				end
			endcase
		end
	end

	assign np = item.final_byte ? PH_IDLE : ph_proc;

	// Results: the byte's own result first, then the one that closes the message.
	always_comb begin
		r0_vld          = 1'b0;
		r0.kind         = KIND_BYTE;
		r0.value_byte   = b;
		r0.value_length = nc;
		r0.run_last     = 1'b0;
		if (in_range) begin
			unique case (e_phase)
				PH_BLANKS: begin
					if (!is_blank && (b != CH_QUOTE))
						r0_vld = 1'b1;
					if (is_delim) begin
						r0.kind       = KIND_DONE;
						r0.value_byte = 8'd0;
						r0.run_last   = item.final_byte;
					end
				end
				PH_VALUE: begin
					r0_vld = 1'b1;
					if ((e_inq && !e_esc && (b == CH_QUOTE)) || (!e_inq && is_delim)) begin
						r0.kind       = KIND_DONE;
						r0.value_byte = 8'd0;
						r0.run_last   = item.final_byte;
					end
				end
				PH_SEARCH, PH_IDLE: begin
					r0_vld = 1'b0;
				end
			endcase
		end
	end

	assign closed = r0_vld && (r0.kind == KIND_DONE);

	always_comb begin
		r1_vld          = item.final_byte && !closed && (ph_proc != PH_IDLE);
		r1.value_byte   = 8'd0;
		r1.run_last     = 1'b1;
		if ((ph_proc == PH_SEARCH) || (ph_proc == PH_BLANKS)) begin
			r1.kind         = KIND_NONE;
			r1.value_length = '0;
		end else begin
			r1.kind         = KIND_DONE;
			r1.value_length = nc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			fill_q  <= '0;
			inq_q   <= 1'b0;
			esc_q   <= 1'b0;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else if (take) begin
			phase_q <= np;
			fill_q  <= nfill;
			inq_q   <= nq;
			esc_q   <= item.final_byte ? 1'b0 : ne;
			cnt_q   <= nc;
			pos_q   <= npos;
		end
	end

	always_ff @(posedge clk) begin
		if (take && shift) begin
			for (int j = 0; j < KEY_MAX; j++)
				win_q[j] <= win_n[j];
		end
	end

endmodule

>>> rtl/kve_out.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-slot output register: takes both results of one byte at once and hands
// them to the result channel one transfer at a time.
// ----------------------------------------------------------------------------
`include "json_key_value_extractor_defines.svh"

module kve_out import kve_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  logic      r0_vld,
	input  res_item_t r0,
	input  logic      r1_vld,
	input  res_item_t r1,
	output logic      can_load,
	kve_res_if.source res
);

	logic      va_q, vb_q;
	res_item_t a_q, b_q, head;
	logic      pop;

	assign head             = va_q ? a_q : b_q;
	assign res.valid        = va_q | vb_q;
	assign res.kind         = head.kind;
	assign res.value_byte   = head.value_byte;
	assign res.value_length = head.value_length;
	assign res.run_last     = head.run_last;

	assign pop      = res.valid && res.ready;
	assign can_load = (!va_q && !vb_q) || (pop && (va_q ^ vb_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
			vb_q <= 1'b0;
		end else if (load) begin
			va_q <= r0_vld;
			vb_q <= r1_vld;
		end else if (pop) begin
			if (va_q)
				va_q <= 1'b0;
			else
				vb_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= r0;
			b_q <= r1;
		end
	end

	`KVE_ASSERT_SAME(a_load_when_free, clk, arst_n, load, (!va_q && !vb_q) || (pop && (va_q ^ vb_q)), "result buffer loaded while still holding a pending result")
	`KVE_ASSERT_SAME(a_second_closes, clk, arst_n, vb_q, b_q.kind != KIND_BYTE, "second slot holds a value byte")
	`KVE_ASSERT_NEXT(a_stall_holds_second, clk, arst_n, vb_q && !va_q && !pop && !load, vb_q && $stable(b_q), "pending closing result lost under stall")

endmodule

>>> rtl/json_key_value_extractor.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor: a byte's results pass the input register, then the result buffer.
// Throughput one byte per cycle while the result buffer can load, set by the parse step on the input register.
// A byte that causes two results holds the result register for two transfers.
// Reset clears parse state and output valids; the key window needs no clearing pass.
// ----------------------------------------------------------------------------
module json_key_value_extractor import kve_pkg::*; #(
	parameter int unsigned KEY_MAX = 16,
	parameter int unsigned MSG_MAX = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	kve_msg_if.sink     msg,
	kve_res_if.source   res
);

	cfg_t      cfg_q;
	msg_item_t item_s1;
	logic      vld_s1;
	logic      take, can_load;
	logic      r0_vld, r1_vld;
	res_item_t r0, r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_low  <= '0;
			cfg_q.key_high <= '0;
			cfg_q.key_len  <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_LOW:  cfg_q.key_low  <= cfg_data;
				CFG_KEY_HIGH: cfg_q.key_high <= cfg_data;
				CFG_KEY_LEN:  cfg_q.key_len  <= cfg_data[4:0];
				default:      cfg_q.key_len  <= cfg_q.key_len;
			endcase
		end
	end

	// The input register advances whenever the result buffer can take its results.
	assign take      = vld_s1 && can_load;
	assign msg.ready = !vld_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (msg.valid && msg.ready)
			vld_s1 <= 1'b1;
		else if (take)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			item_s1.data_byte  <= msg.data_byte;
			item_s1.first_byte <= msg.first_byte;
			item_s1.final_byte <= msg.final_byte;
		end
	end

	kve_step #(
		.KEY_MAX (KEY_MAX),
		.MSG_MAX (MSG_MAX)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.take   (take),
		.r0_vld (r0_vld),
		.r0     (r0),
		.r1_vld (r1_vld),
		.r1     (r1)
	);

	kve_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.r0_vld   (r0_vld),
		.r0       (r0),
		.r1_vld   (r1_vld),
		.r1       (r1),
		.can_load (can_load),
		.res      (res)
	);

endmodule
